@@ hw/rtl/bpc_pkg.sv @@
// Shared types, constants and register map for the block permutation cipher.
// No dependencies; every other file in hw/rtl except bpc_ram imports this package.
package bpc_pkg;

   localparam int MAX_BLOCK_DEF = 8;   // default block store depth
   localparam int KEY_SLOTS     = 8;   // entries held in key_order
   localparam int KEY_W         = 3;   // bits per key entry
   localparam int LEN_W         = 4;   // key_length / fill count width
   localparam int BYTE_W        = 8;
   localparam int ADDR_W        = 4;   // csr byte address width
   localparam int DATA_W        = 32;  // csr data width
   localparam int REG_IDX_W     = 2;

   localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h20;

   // Register indexes (byte address = 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_KEY_ORDER  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_MODE       = 2'd2;

   localparam logic [KEY_SLOTS*KEY_W-1:0] KEY_ORDER_RST  = 24'hFAC688;
   localparam logic [LEN_W-1:0]           KEY_LENGTH_RST = 4'd8;
   localparam logic                       MODE_RST       = 1'b0;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              message_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_last;
      logic              message_last;
      logic              key_error;
   } rsp_type;

   typedef struct packed {
      logic [KEY_SLOTS*KEY_W-1:0] key_order;
      logic [LEN_W-1:0]           key_length;
      logic                       mode;
   } cfg_type;

   // Decoded key: effective length, validity and per-output source position
   typedef struct packed {
      logic [LEN_W-1:0]                len;
      logic                            valid;
      logic [KEY_SLOTS-1:0][KEY_W-1:0] src;
   } key_info_type;

   typedef enum logic [2:0] {
      ST_FILL = 3'b001,
      ST_EMIT = 3'b010,
      ST_ERR  = 3'b100
   } state_type;

endpackage

@@ hw/rtl/block_permutation_cipher_top.sv @@
// Top level of the block permutation cipher: fill/emit sequencer around the
// block store RAM. Depends on bpc_pkg, bpc_csr, bpc_key, bpc_ram.
//
//   port group   dir   flow control        carries
//   req_*        in    req_valid/req_ready req_type: data_byte, message_end
//   rsp_*        out   rsp_valid/rsp_ready rsp_type: out_byte, run_last, ...
//   p* (APB)     in/out psel/penable     key_order, key_length, mode
//
// With a valid key, a byte that ends a block starts L reads out of the block
// store (one RAM read port, one entry per cycle while rsp is not stalled);
// req_ready stays low until the last read issues. Results pass the RAM read
// register and the response register and leave at one per cycle while
// rsp_ready is high. Reset is synchronous; no clearing pass is needed.
// An rsp stall backs up the read stage and then holds the sequencer.
module block_permutation_cipher_top #(
   parameter int MAX_BLOCK = bpc_pkg::MAX_BLOCK_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  bpc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output bpc_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0] paddr,
   input  logic [bpc_pkg::DATA_W-1:0] pwdata,
   output logic [bpc_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import bpc_pkg::*;

   localparam int AW  = $clog2(MAX_BLOCK);
   localparam int LIM = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;

   cfg_type           cfg;
   key_info_type      key;
   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              last_ff, last_in;
   logic [KEY_W-1:0]  idx_ff, idx_in;
   logic              pend_ff, pend_in;
   logic              pend_pad_ff, pend_pad_in;
   logic              pend_rl_ff, pend_rl_in;
   logic              pend_ml_ff, pend_ml_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [BYTE_W-1:0] ram_rd_data;
   logic              accept, issue, move_p, err_load, block_end, issue_rl;
   logic [LEN_W-1:0]  pos, cnt_new;
   logic [KEY_W-1:0]  src_sel;
   logic [AW-1:0]     wr_addr, rd_addr;

   bpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpc_key #(.MAX_BLOCK(MAX_BLOCK)) u_key (
      .cfg  (cfg),
      .info (key)
   );

   bpc_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_BLOCK)) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_data.data_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_FILL);
   assign accept    = req_valid && req_ready;

   // a shrunk length makes the new byte overwrite the last slot
   assign pos       = (fill_ff < key.len) ? fill_ff : key.len - LEN_W'(1);
   assign cnt_new   = pos + LEN_W'(1);
   assign block_end = (cnt_new >= key.len) || req_data.message_end;
   assign wr_addr   = pos[AW-1:0];

   assign move_p   = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue    = (state_ff == ST_EMIT) && (!pend_ff || move_p);
   assign err_load = (state_ff == ST_ERR) && !pend_ff && (!rsp_valid_ff || rsp_ready);
   assign src_sel  = key.src[idx_ff];
   assign rd_addr  = AW'(src_sel);
   assign issue_rl = (({1'b0, idx_ff} + LEN_W'(1)) == key.len);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (block_end) begin
                  fill_in = '0;
                  if (key.valid) begin
                     state_in = ST_EMIT;
                     idx_in   = '0;
                     count_in = cnt_new;
                     last_in  = req_data.message_end;
                  end else if (req_data.message_end) begin
                     state_in = ST_ERR;
                  end
               end else begin
                  fill_in = cnt_new;
               end
            end
         end
         ST_EMIT: begin
            if (issue) begin
               idx_in = idx_ff + KEY_W'(1);
               if (issue_rl) state_in = ST_FILL;
            end
         end
         ST_ERR: begin
            if (err_load) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // read stage: RAM data plus the tags that go with it
   always_comb begin
      pend_in     = pend_ff;
      pend_pad_in = pend_pad_ff;
      pend_rl_in  = pend_rl_ff;
      pend_ml_in  = pend_ml_ff;
      if (issue) begin
         pend_in     = 1'b1;
         pend_pad_in = ({1'b0, src_sel} >= count_ff);
         pend_rl_in  = issue_rl;
         pend_ml_in  = issue_rl && last_ff;
      end else if (move_p) begin
         pend_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (move_p) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_byte     = pend_pad_ff ? PAD_BYTE : ram_rd_data;
         rsp_in.run_last     = pend_rl_ff;
         rsp_in.message_last = pend_ml_ff;
         rsp_in.key_error    = 1'b0;
      end else if (err_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.out_byte     = '0;
         rsp_in.run_last     = 1'b1;
         rsp_in.message_last = 1'b1;
         rsp_in.key_error    = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      last_ff     <= last_in;
      idx_ff      <= idx_in;
      pend_pad_ff <= pend_pad_in;
      pend_rl_ff  <= pend_rl_in;
      pend_ml_ff  <= pend_ml_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_error_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.key_error |->
         rsp_data.run_last && rsp_data.message_last && rsp_data.out_byte == '0)
      else $error("error result with data or missing last flags");

   a_fill_below_limit: assert property (@(posedge clock) disable iff (reset)
      fill_ff < LEN_W'(LIM))
      else $error("fill count reached block limit");

   a_block_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.run_last |=> rsp_valid)
      else $error("gap inside an emitted block");

   a_no_accept_while_reading: assert property (@(posedge clock) disable iff (reset)
      issue |-> !accept)
      else $error("block store written during emit reads");
`endif

endmodule

@@ hw/rtl/bpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the block store.
module bpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bpc_csr.sv @@
// APB-style configuration registers: key_order, key_length, mode.
// Depends on bpc_pkg.
module bpc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0]  paddr,
   input  logic [bpc_pkg::DATA_W-1:0]  pwdata,
   output logic [bpc_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output bpc_pkg::cfg_type            cfg
);
   import bpc_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_strobe;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_KEY_ORDER:  cfg_in.key_order  = pwdata[KEY_SLOTS*KEY_W-1:0];
            REG_KEY_LENGTH: cfg_in.key_length = pwdata[LEN_W-1:0];
            REG_MODE:       cfg_in.mode       = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY_ORDER:  prdata = DATA_W'(cfg_ff.key_order);
         REG_KEY_LENGTH: prdata = DATA_W'(cfg_ff.key_length);
         REG_MODE:       prdata = DATA_W'(cfg_ff.mode);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_order  <= KEY_ORDER_RST;
         cfg_ff.key_length <= KEY_LENGTH_RST;
         cfg_ff.mode       <= MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/bpc_key.sv @@
// Key decode: effective block length, permutation check and source map
// (key entries for encode, inverse permutation for decode). Depends on bpc_pkg.
module bpc_key #(
   parameter int MAX_BLOCK = bpc_pkg::MAX_BLOCK_DEF
) (
   input  bpc_pkg::cfg_type      cfg,
   output bpc_pkg::key_info_type info
);
   import bpc_pkg::*;

   localparam int LIM = (MAX_BLOCK < KEY_SLOTS) ? MAX_BLOCK : KEY_SLOTS;

   logic [LEN_W-1:0]                len;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] ent;
   logic [KEY_SLOTS-1:0][KEY_W-1:0] inv;
   logic                            ok;

   always_comb begin
      len = cfg.key_length;
      if (len == '0) len = LEN_W'(1);
      if (len > LEN_W'(LIM)) len = LEN_W'(LIM);
   end

   always_comb begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
         ent[k] = cfg.key_order[k*KEY_W +: KEY_W];
      end
   end

   // every used entry in range and no two used entries equal
   always_comb begin
      ok = 1'b1;
      for (int k = 0; k < KEY_SLOTS; k++) begin
         if (LEN_W'(k) < len) begin
            if ({1'b0, ent[k]} >= len) ok = 1'b0;
            for (int j = 0; j < k; j++) begin
               if (ent[j] == ent[k]) ok = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
         inv[k] = '0;
         for (int j = 0; j < KEY_SLOTS; j++) begin
            if (LEN_W'(j) < len && ent[j] == KEY_W'(k)) inv[k] = inv[k] | KEY_W'(j);
         end
      end
   end

   assign info.len   = len;
   assign info.valid = ok;
   assign info.src   = cfg.mode ? inv : ent;

endmodule
